[rtl/fp16_bf16_fp32_converter_top_assert.svh]
// ----------------------------------------------------------------------------
// fp16_bf16_fp32_converter_top_assert.svh
// Assertion macros for the format converter.
// ----------------------------------------------------------------------------
`ifndef FP16_BF16_FP32_CONVERTER_TOP_ASSERT_SVH
`define FP16_BF16_FP32_CONVERTER_TOP_ASSERT_SVH

// same-cycle implication
`define FBFC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FBFC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/fbfc_pkg.sv]
// ----------------------------------------------------------------------------
// fbfc_pkg
// Types and constants shared by the format converter.
// ----------------------------------------------------------------------------
package fbfc_pkg;

   typedef enum logic [1:0] {
      CMD_H2S  = 2'd0,
      CMD_S2H  = 2'd1,
      CMD_BF2S = 2'd2,
      CMD_S2BF = 2'd3
   } cmd_type;

   localparam logic [15:0] SIGN16     = 16'h8000;
   localparam logic [7:0]  EXP_REBIAS = 8'd112;
   localparam logic [31:0] EXP_ALL32  = 32'h7f80_0000;
   localparam logic [15:0] EXP_ALL16  = 16'h7c00;
   localparam logic [15:0] QUIET16    = 16'h0200;
   localparam logic [23:0] HALF_ULP   = 24'h00_1000;
   localparam logic [23:0] HIDDEN32   = 24'h80_0000;
   localparam logic [31:0] BF_HALF    = 32'h0000_7fff;

   localparam logic [7:0]  SUB_BIAS   = 8'd113;
   localparam logic [7:0]  ZERO_RAW   = 8'd102;
   localparam logic [7:0]  OVF_RAW    = 8'd143;
   localparam logic [7:0]  RAW_ALL1   = 8'hff;
   localparam logic [4:0]  HEXP_ALL1  = 5'h1f;

endpackage

[rtl/fbfc_stream_if.sv]
// ----------------------------------------------------------------------------
// fbfc_stream_if
// Valid/ready channels for request and response beats.
// ----------------------------------------------------------------------------
interface fbfc_req_if import fbfc_pkg::*; ();
   logic        valid;
   logic        ready;
   cmd_type     command;
   logic [31:0] operand;

   modport source (output valid, output command, output operand, input ready);
   modport sink   (input valid, input command, input operand, output ready);
endinterface

interface fbfc_rsp_if import fbfc_pkg::*; ();
   logic        valid;
   logic        ready;
   logic [31:0] converted;

   modport source (output valid, output converted, input ready);
   modport sink   (input valid, input converted, output ready);
endinterface

[rtl/fbfc_convert.sv]
// ----------------------------------------------------------------------------
// fbfc_convert
// Combinational half / bfloat16 / single conversion of one operand.
// ----------------------------------------------------------------------------
module fbfc_convert import fbfc_pkg::*; (
   input  cmd_type     command,
   input  logic [31:0] operand,
   output logic [31:0] converted
);

   logic        h_sign;
   logic [4:0]  h_exp;
   logic [9:0]  h_man;
   logic [3:0]  h_shift;
   logic [10:0] h_norm;
   logic [7:0]  h_sub_exp;
   logic [31:0] h2s;

   logic        s_sign;
   logic [7:0]  s_raw;
   logic [22:0] s_man;
   logic [15:0] s_sign16;
   logic [3:0]  s_shift;
   logic [23:0] s_sub_norm;
   logic [24:0] s_sub_rnd;
   logic [23:0] s_man_rnd;
   logic [4:0]  s_exp;
   logic [14:0] s_nrm;
   logic [15:0] s2h;

   logic [31:0] bf_sum;

   assign h_sign = operand[15];
   assign h_exp  = operand[14:10];
   assign h_man  = operand[9:0];

   always_comb begin
      h_shift = 4'd0;
      for (int i = 0; i < 10; i++) begin
         if (h_man[i]) begin
            h_shift = 4'(10 - i);
         end
      end
   end

   assign h_norm    = {1'b0, h_man} << h_shift;
   assign h_sub_exp = SUB_BIAS - {4'b0, h_shift};

   always_comb begin
      if (h_exp == 5'd0 && h_man == 10'd0) begin
         h2s = {h_sign, 31'b0};
      end else if (h_exp == 5'd0) begin
         h2s = {h_sign, h_sub_exp, h_norm[9:0], 13'b0};
      end else if (h_exp == HEXP_ALL1) begin
         h2s = {h_sign, 31'b0} | EXP_ALL32 | {9'b0, h_man, 13'b0};
      end else begin
         h2s = {h_sign, {3'b0, h_exp} + EXP_REBIAS, h_man, 13'b0};
      end
   end

   assign s_sign     = operand[31];
   assign s_raw      = operand[30:23];
   assign s_man      = operand[22:0];
   assign s_sign16   = s_sign ? SIGN16 : 16'h0000;
   assign s_shift    = 4'(SUB_BIAS - s_raw);
   assign s_sub_norm = ({1'b0, s_man} | HIDDEN32) >> s_shift;
   assign s_sub_rnd  = {1'b0, s_sub_norm} + {1'b0, HALF_ULP};
   assign s_man_rnd  = {1'b0, s_man} + HALF_ULP;
   assign s_exp      = 5'(s_raw - EXP_REBIAS);
   assign s_nrm      = {s_exp, 10'b0} + {4'b0, s_man_rnd[23:13]};

   always_comb begin
      if (s_raw == RAW_ALL1) begin
         s2h = s_sign16 | EXP_ALL16 | ((s_man != 23'd0) ? QUIET16 : 16'h0000);
      end else if (s_raw < ZERO_RAW) begin
         s2h = s_sign16;
      end else if (s_raw < SUB_BIAS) begin
         s2h = s_sign16 | {5'b0, s_sub_rnd[23:13]};
      end else if (s_raw >= OVF_RAW) begin
         s2h = s_sign16 | EXP_ALL16;
      end else begin
         s2h = {s_sign, s_nrm};
      end
   end

   assign bf_sum = operand + BF_HALF + {31'b0, operand[16]};

   always_comb begin
      case (command)
         CMD_H2S:  converted = h2s;
         CMD_S2H:  converted = {16'b0, s2h};
         CMD_BF2S: converted = {operand[15:0], 16'b0};
         CMD_S2BF: converted = {16'b0, bf_sum[31:16]};
         default:  converted = h2s;
      endcase
   end

endmodule

[rtl/fp16_bf16_fp32_converter_top.sv]
// An accepted beat goes through the input register, then the response register.
// Throughput: one beat per cycle; stages advance whenever the response side
//   takes its beat or the response register is empty.
// The path is input register, conversion logic, response register.
// Reset (synchronous) empties both stages; payload registers are not cleared.
// ----------------------------------------------------------------------------
// fp16_bf16_fp32_converter_top
// Half / bfloat16 / single format converter with valid/ready channels.
// ----------------------------------------------------------------------------
`include "fp16_bf16_fp32_converter_top_assert.svh"

module fp16_bf16_fp32_converter_top import fbfc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   fbfc_req_if.sink     req_chan,
   fbfc_rsp_if.source   rsp_chan
);

   logic        in_valid_ff;
   logic        in_valid_in;
   cmd_type     in_cmd_ff;
   logic [31:0] in_op_ff;
   logic        out_valid_ff;
   logic        out_valid_in;
   logic [31:0] out_data_ff;
   logic [31:0] conv_result;
   logic        out_free;
   logic        out_load;
   logic        req_take;

   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign out_load = in_valid_ff && out_free;
   assign req_chan.ready = !in_valid_ff || out_free;
   assign req_take = req_chan.valid && req_chan.ready;

   assign in_valid_in  = req_take || (in_valid_ff && !out_free);
   assign out_valid_in = out_load || (out_valid_ff && !rsp_chan.ready);

   fbfc_convert u_convert (
      .command   (in_cmd_ff),
      .operand   (in_op_ff),
      .converted (conv_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_cmd_ff <= req_chan.command;
         in_op_ff  <= req_chan.operand;
      end
      if (out_load) begin
         out_data_ff <= conv_result;
      end
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.converted = out_data_ff;

   `FBFC_ASSERT_NOW(a_stall_blocks, in_valid_ff && out_valid_ff && !rsp_chan.ready, !req_chan.ready, "request taken while both stages stalled")
   `FBFC_ASSERT_NEXT(a_take_fills, req_take, in_valid_ff, "accepted beat lost from input stage")
   `FBFC_ASSERT_NEXT(a_load_shows, out_load, rsp_chan.valid, "converted beat not presented")
   `FBFC_ASSERT_NEXT(a_half_upper, out_load && (in_cmd_ff == CMD_S2H || in_cmd_ff == CMD_S2BF), rsp_chan.converted[31:16] == 16'h0000, "16-bit result has upper bits set")

endmodule

[verif/fp16_bf16_fp32_converter_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fp16_bf16_fp32_converter_top_tb
// Checks every response beat of the format converter against its own
// predictor. Covers half, bfloat16 and single conversions, boundary
// operands, random operands and random idling on both channels.
// ----------------------------------------------------------------------------
module fp16_bf16_fp32_converter_top_tb import fbfc_pkg::*; ();

   localparam int CLOCK_HALF     = 5;
   localparam int RESET_CYCLES   = 11;
   localparam int RANDOM_BEATS   = 1550;
   localparam int STEADY_FROM    = 1350;
   localparam int LONG_HOLD      = 40;
   localparam int LONG_HOLD_AT   = 300;
   localparam int DRAIN_CYCLES   = 10;
   localparam int CYCLE_LIMIT    = 100000;
   localparam int REPORT_LIMIT   = 10;

   localparam logic [31:0] MAN32_MASK   = 32'h007f_ffff;
   localparam logic [31:0] IMPLICIT_ONE = 32'h0080_0000;
   localparam logic [31:0] ROUND_HALF   = 32'h0000_1000;
   localparam logic [31:0] BF_ROUND     = 32'h0000_7fff;
   localparam logic [15:0] HALF_INF     = 16'h7c00;
   localparam logic [15:0] HALF_QUIET   = 16'h0200;
   localparam int          HALF_BIAS_GAP = 112;

   typedef struct {
      cmd_type     command;
      logic [31:0] operand;
      logic [31:0] converted;
   } conversion_type;

   class conversion_scoreboard;
      conversion_type pending_conversions[$];
      int             mismatches;

      function new();
         mismatches = 0;
      endfunction

      function logic [31:0] half_to_single(logic [15:0] h);
         logic [4:0]  ex;
         logic [10:0] man;
         int          shifts;
         ex = h[14:10];
         man = {1'b0, h[9:0]};
         shifts = 0;
         if (ex == 5'd0) begin
            if (man == 11'd0)
               return {h[15], 31'd0};
            while (!man[10] && shifts < 11) begin
               man = man << 1;
               shifts++;
            end
            return {h[15], 8'(HALF_BIAS_GAP + 1 - shifts), man[9:0], 13'd0};
         end
         if (ex == 5'h1f)
            return {h[15], 8'hff, h[9:0], 13'd0};
         return {h[15], 8'({3'd0, ex} + 8'(HALF_BIAS_GAP)), h[9:0], 13'd0};
      endfunction

      function logic [31:0] single_to_half(logic [31:0] s);
         logic [15:0] sign;
         logic [31:0] man;
         logic [31:0] norm;
         logic [7:0]  raw;
         int          ex;
         sign = {s[31], 15'd0};
         man = s & MAN32_MASK;
         raw = s[30:23];
         ex = int'(raw) - HALF_BIAS_GAP;
         if (raw == 8'hff)
            return {16'd0, sign | HALF_INF | (man != 32'd0 ? HALF_QUIET : 16'd0)};
         if (ex <= 0) begin
            if (ex < -10)
               return {16'd0, sign};
            norm = (man | IMPLICIT_ONE) >> (1 - ex);
            norm = (norm + ROUND_HALF) >> 13;
            return {16'd0, sign | norm[15:0]};
         end
         if (ex >= 31)
            return {16'd0, sign | HALF_INF};
         norm = (32'(ex) << 10) + ((man + ROUND_HALF) >> 13);
         return {16'd0, sign | {1'b0, norm[14:0]}};
      endfunction

      function logic [31:0] single_to_bfloat(logic [31:0] s);
         logic [31:0] rounded;
         rounded = s + BF_ROUND + {31'd0, s[16]};
         return {16'd0, rounded[31:16]};
      endfunction

      function logic [31:0] converted_word(cmd_type cmd, logic [31:0] op);
         case (cmd)
            CMD_H2S:  return half_to_single(op[15:0]);
            CMD_S2H:  return single_to_half(op);
            CMD_BF2S: return {op[15:0], 16'd0};
            default:  return single_to_bfloat(op);
         endcase
      endfunction

      function void note_request(cmd_type cmd, logic [31:0] op);
         conversion_type entry;
         entry.command = cmd;
         entry.operand = op;
         entry.converted = converted_word(cmd, op);
         pending_conversions.push_back(entry);
      endfunction

      function void check_response(logic [31:0] actual);
         conversion_type entry;
         if (pending_conversions.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected response beat: converted %h", actual);
            return;
         end
         entry = pending_conversions.pop_front();
         if (actual !== entry.converted) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("mismatch: %s operand %h expected %h actual %h",
                        entry.command.name(), entry.operand, entry.converted, actual);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int   beats_sent;
   int   idle_pct;
   int   cycle_count;
   bit   long_hold_done;

   conversion_scoreboard scoreboard = new();

   fbfc_req_if req_if ();
   fbfc_rsp_if rsp_if ();

   fp16_bf16_fp32_converter_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   initial clock = 1'b0;

   always #(CLOCK_HALF) clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("fp16_bf16_fp32_converter_top verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         scoreboard.check_response(rsp_if.converted);
   end

   task automatic send_request(cmd_type cmd, logic [31:0] op);
      int gap;
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         gap = $urandom_range(1, 4);
         req_if.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid = 1'b1;
      req_if.command = cmd;
      req_if.operand = op;
      do
         @(posedge clock);
      while (!req_if.ready);
      scoreboard.note_request(cmd, op);
      beats_sent++;
      @(negedge clock);
   endtask

   function automatic logic [31:0] random_operand(cmd_type cmd);
      logic [31:0] word;
      logic [7:0]  raw;
      word = $urandom;
      if ($urandom_range(0, 1) == 0)
         return word;
      case (cmd)
         CMD_H2S: begin
            case ($urandom_range(0, 3))
               0:       word[14:10] = 5'h00;
               1:       word[14:10] = 5'h1f;
               2:       word[14:10] = 5'h01;
               default: word[14:10] = 5'h1e;
            endcase
            if ($urandom_range(0, 3) == 0)
               word[9:0] = 10'h001 << $urandom_range(0, 9);
         end
         CMD_S2H: begin
            case ($urandom_range(0, 5))
               0:       raw = 8'(101 + $urandom_range(0, 12));
               1:       raw = 8'(141 + $urandom_range(0, 3));
               2:       raw = 8'hff;
               3:       raw = 8'h00;
               4:       raw = 8'hfe;
               default: raw = 8'(113 + $urandom_range(0, 29));
            endcase
            word[30:23] = raw;
            if ($urandom_range(0, 2) == 0)
               word[12:0] = $urandom_range(0, 1) ? 13'h1000 : 13'h0fff;
            if ($urandom_range(0, 3) == 0)
               word[22:13] = 10'h3ff;
            if ($urandom_range(0, 5) == 0)
               word[22:0] = 23'd0;
         end
         CMD_S2BF: begin
            if ($urandom_range(0, 1) == 0)
               word[15:0] = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
            if ($urandom_range(0, 3) == 0)
               word[30:23] = 8'hff;
            if ($urandom_range(0, 3) == 0)
               word[22:16] = 7'h7f;
         end
         default: ;
      endcase
      return word;
   endfunction

   // receiver: random stalls, one long hold-off to back up the pipeline
   initial begin
      rsp_if.ready = 1'b0;
      while (reset !== 1'b0)
         @(negedge clock);
      forever begin
         if (!long_hold_done && beats_sent >= LONG_HOLD_AT) begin
            rsp_if.ready = 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            long_hold_done = 1'b1;
         end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            rsp_if.ready = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clock);
         end else begin
            rsp_if.ready = 1'b1;
            @(negedge clock);
         end
      end
   end

   initial begin
      cmd_type cmd;
      req_if.valid = 1'b0;
      req_if.command = CMD_H2S;
      req_if.operand = 32'd0;
      reset = 1'b1;
      beats_sent = 0;
      cycle_count = 0;
      long_hold_done = 1'b0;
      idle_pct = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // half to single: zeros, subnormals, normal limits, negative infinity, NaN
      send_request(CMD_H2S, 32'h0000_0000);
      send_request(CMD_H2S, 32'h0000_8000);
      send_request(CMD_H2S, 32'h0000_0001);
      send_request(CMD_H2S, 32'hffff_83ff);
      send_request(CMD_H2S, 32'h0000_0400);
      send_request(CMD_H2S, 32'ha5a5_7bff);
      send_request(CMD_H2S, 32'h0000_fc00);
      send_request(CMD_H2S, 32'h0000_7e01);
      // single to half: flush to zero, subnormal range, rounding carry, overflow, infinity, NaN
      send_request(CMD_S2H, 32'h8000_0001);
      send_request(CMD_S2H, 32'h3300_0000);
      send_request(CMD_S2H, 32'h387f_f000);
      send_request(CMD_S2H, 32'h477f_e000);
      send_request(CMD_S2H, 32'h477f_f000);
      send_request(CMD_S2H, 32'hff7f_ffff);
      send_request(CMD_S2H, 32'h7f80_0000);
      send_request(CMD_S2H, 32'hff80_0001);
      send_request(CMD_S2H, 32'h3f80_0000);
      // bfloat16 to single
      send_request(CMD_BF2S, 32'hffff_ffff);
      send_request(CMD_BF2S, 32'h1234_8000);
      // single to bfloat16: ties to even, NaN wrap, full wrap, overflow to infinity, zero
      send_request(CMD_S2BF, 32'h3f80_8000);
      send_request(CMD_S2BF, 32'h3f81_8000);
      send_request(CMD_S2BF, 32'h7fff_ffff);
      send_request(CMD_S2BF, 32'hffff_ffff);
      send_request(CMD_S2BF, 32'h7f7f_ffff);
      send_request(CMD_S2BF, 32'h0000_0000);

      for (int i = 0; i < RANDOM_BEATS; i++) begin
         if (i % 100 == 0) begin
            case ($urandom_range(0, 3))
               0:       idle_pct = 0;
               1:       idle_pct = 10;
               2:       idle_pct = 25;
               default: idle_pct = 40;
            endcase
         end
         if (i >= STEADY_FROM)
            idle_pct = 0;
         cmd = cmd_type'($urandom_range(0, 3));
         send_request(cmd, random_operand(cmd));
      end
      req_if.valid = 1'b0;

      while (scoreboard.pending_conversions.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (scoreboard.mismatches == 0 && scoreboard.pending_conversions.size() == 0) begin
         $display("fp16_bf16_fp32_converter_top verification clean");
      end else begin
         $display("fp16_bf16_fp32_converter_top verification failed");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl
rtl/fbfc_pkg.sv
rtl/fbfc_stream_if.sv
rtl/fbfc_convert.sv
rtl/fp16_bf16_fp32_converter_top.sv
verif/fp16_bf16_fp32_converter_top_tb.sv
